@@ rtl/bmd_pkg.sv @@
// Package for the binary message deframer: phase codes, status codes,
// framing bytes and the result record. No dependencies.
`default_nettype none

package bmd_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_HI    = 8'hA0;
  localparam logic [7:0] SYNC_LO    = 8'hA1;
  localparam logic [7:0] END_FIRST  = 8'h0D;
  localparam logic [7:0] END_SECOND = 8'h0A;

  // Reset values of the configuration registers
  localparam logic [15:0] MAX_LEN_RESET   = 16'd256;
  localparam logic [7:0]  SYNC_LIM_RESET  = 8'd100;

  // Configuration register indexes
  localparam logic CFG_MAX_PAYLOAD_LEN   = 1'b0;
  localparam logic CFG_SYNC_SEARCH_LIMIT = 1'b1;

  // Receiver phases
  localparam logic [2:0] PH_HUNT     = 3'd0;
  localparam logic [2:0] PH_LEN_HI   = 3'd1;
  localparam logic [2:0] PH_LEN_LO   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD  = 3'd3;
  localparam logic [2:0] PH_CHECKSUM = 3'd4;
  localparam logic [2:0] PH_END1     = 3'd5;
  localparam logic [2:0] PH_END2     = 3'd6;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SYNC  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_CSUM_BAD = 3'd3;
  localparam logic [2:0] ST_BAD_END  = 3'd4;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] frame_len;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/bmd_fsm.sv @@
// Frame receive state machine with the configuration registers.
// Depends on bmd_pkg; produces at most one result per accepted byte.
`default_nettype none

module bmd_fsm import bmd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_take,
  input  wire logic [7:0]  in_byte,
  output logic             res_valid,
  output res_t             res
);

  logic [15:0] max_len;
  logic [7:0]  sync_lim;

  logic [2:0]  phase, phase_next;
  logic        prev_hi, prev_hi_next;
  logic [7:0]  skip_count, skip_count_next;
  logic [15:0] payload_len, payload_len_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        checksum_bad, checksum_bad_next;
  logic        end_first_ok, end_first_ok_next;

  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign len_full  = {payload_len[15:8], in_byte};
  assign count_inc = byte_count + 16'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len  <= MAX_LEN_RESET;
      sync_lim <= SYNC_LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD_LEN:   max_len  <= cfg_wdata;
        CFG_SYNC_SEARCH_LIMIT: sync_lim <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Next state and result for one byte
  always_comb begin
    phase_next        = phase;
    prev_hi_next      = prev_hi;
    skip_count_next   = skip_count;
    payload_len_next  = payload_len;
    byte_count_next   = byte_count;
    running_xor_next  = running_xor;
    checksum_bad_next = checksum_bad;
    end_first_ok_next = end_first_ok;
    res_valid         = 1'b0;
    res               = '0;

    case (phase)
      PH_LEN_HI: begin
        payload_len_next = {in_byte, 8'h00};
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_len_next = len_full;
        if (len_full > max_len) begin
          res_valid       = 1'b1;
          res.kind        = KIND_STATUS;
          res.status      = ST_TOO_LONG;
          res.frame_len   = len_full;
          phase_next      = PH_HUNT;
          prev_hi_next    = 1'b0;
          skip_count_next = '0;
        end else begin
          byte_count_next  = '0;
          running_xor_next = '0;
          phase_next       = (len_full == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_xor_next = running_xor ^ in_byte;
        byte_count_next  = count_inc;
        if (count_inc == payload_len) begin
          phase_next = PH_CHECKSUM;
        end
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = in_byte;
      end
      PH_CHECKSUM: begin
        checksum_bad_next = (in_byte != running_xor);
        phase_next        = PH_END1;
      end
      PH_END1: begin
        end_first_ok_next = (in_byte == END_FIRST);
        phase_next        = PH_END2;
      end
      PH_END2: begin
        res_valid     = 1'b1;
        res.kind      = KIND_STATUS;
        res.frame_len = payload_len;
        if (!end_first_ok || in_byte != END_SECOND) begin
          res.status = ST_BAD_END;
        end else if (checksum_bad) begin
          res.status = ST_CSUM_BAD;
        end else begin
          res.status = ST_OK;
        end
        phase_next      = PH_HUNT;
        prev_hi_next    = 1'b0;
        skip_count_next = '0;
      end
      default: begin
        // Hunting; also covers the unused phase code
        phase_next = PH_HUNT;
        if (skip_count == sync_lim) begin
          res_valid       = 1'b1;
          res.kind        = KIND_STATUS;
          res.status      = ST_NO_SYNC;
          prev_hi_next    = 1'b0;
          skip_count_next = '0;
        end else if (prev_hi && in_byte == SYNC_LO) begin
          phase_next      = PH_LEN_HI;
          prev_hi_next    = 1'b0;
          skip_count_next = '0;
        end else begin
          skip_count_next = skip_count + 8'd1;
          prev_hi_next    = (in_byte == SYNC_HI);
        end
      end
    endcase

    if (!in_take) begin
      res_valid = 1'b0;
    end
  end

  // State registers, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      prev_hi      <= 1'b0;
      skip_count   <= '0;
      payload_len  <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
      checksum_bad <= 1'b0;
      end_first_ok <= 1'b0;
    end else if (in_take) begin
      phase        <= phase_next;
      prev_hi      <= prev_hi_next;
      skip_count   <= skip_count_next;
      payload_len  <= payload_len_next;
      byte_count   <= byte_count_next;
      running_xor  <= running_xor_next;
      checksum_bad <= checksum_bad_next;
      end_first_ok <= end_first_ok_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmd_outbuf.sv @@
// Two-entry output register with skid stage for result beats.
// Depends on bmd_pkg for the result record.
`default_nettype none

module bmd_outbuf import bmd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire res_t  push_res,
  output logic       space,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  logic main_valid, skid_valid;
  res_t main_res, skid_res;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/binary_message_deframer.sv @@
// Channel     Dir  Width  Contents
// s_axis      in   8      tdata: rx_byte
// m_axis      out  32+1   tdata: data_byte, status, frame_len; tuser: kind
// cfg         in   1+16   index 0 max_payload_len, index 1 sync_search_limit
//
// One byte is taken per cycle while the buffer has space; a result, if any,
// is registered onto m_axis. The state machine updates in the accept cycle.
// A two-entry output buffer keeps s_axis_tready high while one result waits.
// Synchronous reset returns to hunting with the register defaults loaded.
// Depends on bmd_pkg, bmd_fsm and bmd_outbuf.
`default_nettype none

module binary_message_deframer import bmd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] data_byte, [10:8] status,
                                           // [26:11] frame_len, [31:27] zero
  output logic             m_axis_tuser    // [0] kind
);

  logic in_take;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic space;

  assign s_axis_tready = space;
  assign in_take       = s_axis_tvalid && space;

  bmd_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_take   (in_take),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  bmd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result beat
  assign m_axis_tdata = {5'd0, out_res.frame_len, out_res.status, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

@@ verif/binary_message_deframer_tb.sv @@
// Self-checking bench for binary_message_deframer: a directed table of frames, then random
// framed traffic under several limit settings, with random stalls on both streams.
// Depends on bmd_pkg and the binary_message_deframer RTL.
`timescale 1ns / 100ps

module binary_message_deframer_tb;
  import bmd_pkg::*;

  // One row of the directed table; pinned rows carry a typed-in status
  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_RESULT = '0;
  localparam int   N_PHASES  = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MAX_PAYLOAD_LEN;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;        // [7:0] data_byte, [10:8] status, [26:11] frame_len
  logic        m_axis_tuser;        // [0] kind

  // Pinned expectation travelling with the current input beat
  logic        drv_pinned = 1'b0;
  res_t        drv_pinned_res = '0;

  // Frame decoder mirror: limits and receive state
  logic [15:0] lim_max_len;
  logic [7:0]  lim_hunt;
  logic [2:0]  rx_phase;
  logic        after_sync_hi;
  logic [7:0]  hunt_skips;
  logic [15:0] rx_len;
  logic [15:0] payload_seen;
  logic [7:0]  payload_xor;
  logic        csum_mismatch;
  logic        end1_ok;

  res_t        pending_results [$];
  logic [7:0]  rx_backlog [$];
  int          fault_cnt = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          out_stall_left = 0;

  int ph_max   [N_PHASES] = '{256, 0, 65535, 16, 9, 65535};
  int ph_lim   [N_PHASES] = '{100, 255, 1, 5, 20, 255};
  int ph_items [N_PHASES] = '{200, 150, 100, 200, 250, 200};
  int ph_idle  [N_PHASES] = '{30, 25, 20, 0, 50, 0};

  // Directed frames, run with a hunt limit of 2 and the default length limit
  stim_row_t directed_rows [29] = '{
    // hunt limit reached: the A1 that would complete the pair is dropped
    '{8'h33, 1'b0, NO_RESULT},
    '{8'hA0, 1'b0, NO_RESULT},
    '{8'hA1, 1'b1, '{KIND_STATUS, 8'h00, ST_NO_SYNC, 16'h0000}},
    // zero length, good frame
    '{8'hA0, 1'b0, NO_RESULT},
    '{8'hA1, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h0D, 1'b0, NO_RESULT},
    '{8'h0A, 1'b1, '{KIND_STATUS, 8'h00, ST_OK, 16'h0000}},
    // one payload byte, wrong checksum
    '{8'hA0, 1'b0, NO_RESULT},
    '{8'hA1, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h0D, 1'b0, NO_RESULT},
    '{8'h0A, 1'b1, '{KIND_STATUS, 8'h00, ST_CSUM_BAD, 16'h0001}},
    // largest length, rejected at once
    '{8'hA0, 1'b0, NO_RESULT},
    '{8'hA1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{KIND_STATUS, 8'h00, ST_TOO_LONG, 16'hFFFF}},
    // bad checksum and bad end pair together: end pair wins
    '{8'hA0, 1'b0, NO_RESULT},
    '{8'hA1, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h0C, 1'b0, NO_RESULT},
    '{8'h0A, 1'b1, '{KIND_STATUS, 8'h00, ST_BAD_END, 16'h0000}}
  };

  binary_message_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Closing status item; every status sends the decoder back to hunting
  function automatic logic close_frame(output res_t r, input logic [2:0] code,
                                       input logic [15:0] len);
    r = '0;
    r.kind = KIND_STATUS;
    r.status = code;
    r.frame_len = len;
    rx_phase = PH_HUNT;
    after_sync_hi = 1'b0;
    hunt_skips = '0;
    return 1'b1;
  endfunction

  // Advance the mirror by one received byte; returns 1 when a result is due
  function automatic logic deframe_byte(input logic [7:0] b, output res_t r);
    r = '0;
    case (rx_phase)
      PH_LEN_HI: begin
        rx_len = {b, 8'h00};
        rx_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        rx_len = {rx_len[15:8], b};
        if (rx_len > lim_max_len) return close_frame(r, ST_TOO_LONG, rx_len);
        payload_seen = '0;
        payload_xor = '0;
        rx_phase = (rx_len == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        payload_xor ^= b;
        payload_seen = payload_seen + 16'd1;
        if (payload_seen == rx_len) rx_phase = PH_CHECKSUM;
        r.kind = KIND_PAYLOAD;
        r.data_byte = b;
        return 1'b1;
      end
      PH_CHECKSUM: begin
        csum_mismatch = (b != payload_xor);
        rx_phase = PH_END1;
        return 1'b0;
      end
      PH_END1: begin
        end1_ok = (b == END_FIRST);
        rx_phase = PH_END2;
        return 1'b0;
      end
      PH_END2: begin
        if (!end1_ok || b != END_SECOND) return close_frame(r, ST_BAD_END, rx_len);
        return close_frame(r, csum_mismatch ? ST_CSUM_BAD : ST_OK, rx_len);
      end
      default: begin
        // hunting, and the unused phase code
        if (hunt_skips == lim_hunt) return close_frame(r, ST_NO_SYNC, 16'd0);
        if (after_sync_hi && b == SYNC_LO) begin
          rx_phase = PH_LEN_HI;
          after_sync_hi = 1'b0;
          hunt_skips = '0;
          return 1'b0;
        end
        hunt_skips = hunt_skips + 8'd1;
        after_sync_hi = (b == SYNC_HI);
        return 1'b0;
      end
    endcase
  endfunction

  task automatic note_fault(input string what, input res_t want, input res_t got,
                            input logic [4:0] pad);
    fault_cnt++;
    if (fault_cnt <= 10)
      $display({"%s: want kind=%0d byte=%02h st=%0d len=%0d, ",
                "got kind=%0d byte=%02h st=%0d len=%0d pad=%0h"},
               what, want.kind, want.data_byte, want.status, want.frame_len,
               got.kind, got.data_byte, got.status, got.frame_len, pad);
  endtask

  // Output checking first, then prediction of the byte taken at the same edge
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    res_t guess;
    if (rst) begin
      lim_max_len = MAX_LEN_RESET;
      lim_hunt = SYNC_LIM_RESET;
      rx_phase = PH_HUNT;
      after_sync_hi = 1'b0;
      hunt_skips = '0;
      rx_len = '0;
      payload_seen = '0;
      payload_xor = '0;
      csum_mismatch = 1'b0;
      end1_ok = 1'b0;
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.data_byte = m_axis_tdata[7:0];
        got.status = m_axis_tdata[10:8];
        got.frame_len = m_axis_tdata[26:11];
        if (pending_results.size() == 0) begin
          note_fault("unexpected beat", NO_RESULT, got, m_axis_tdata[31:27]);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.status !== want.status || got.frame_len !== want.frame_len ||
              m_axis_tdata[31:27] !== 5'd0)
            note_fault("mismatch", want, got, m_axis_tdata[31:27]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, guess) && !drv_pinned) pending_results.push_back(guess);
        if (drv_pinned) pending_results.push_back(drv_pinned_res);
      end
    end
  end

  // Receiver back-pressure: random stall bursts on m_axis_tready
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_stall_left <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Write both limits on consecutive cycles; only called while idle
  task automatic load_limits(input logic [15:0] max_len, input logic [7:0] hunt);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_PAYLOAD_LEN;
    cfg_wdata <= max_len;
    @(posedge clk);
    lim_max_len = max_len;
    cfg_index <= CFG_SYNC_SEARCH_LIMIT;
    cfg_wdata <= {8'h00, hunt};
    @(posedge clk);
    lim_hunt = hunt;
    cfg_we <= 1'b0;
  endtask

  // Offer one byte, with an optional idle gap in front, and wait for the beat
  task automatic send_rx(input logic [7:0] b, input logic pinned, input res_t want);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    drv_pinned <= pinned;
    drv_pinned_res <= want;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Queue one frame: mostly well formed with random content, some noise and damage
  task automatic add_frame();
    int         sel;
    int         ml;
    int         len;
    logic [7:0] x;
    logic [7:0] pb;
    int         r;
    sel = $urandom_range(0, 99);
    ml = lim_max_len;
    if (sel < 8) begin
      repeat ($urandom_range(1, 6))
        rx_backlog.push_back(($urandom_range(0, 3) == 0) ? SYNC_HI : 8'($urandom));
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) rx_backlog.push_back(8'($urandom));
    rx_backlog.push_back(SYNC_HI);
    rx_backlog.push_back(SYNC_LO);
    if (sel < 20 && ml < 65535) len = $urandom_range(ml + 1, 65535);
    else if (sel < 26 && ml <= 24) len = ml;
    else len = $urandom_range(0, 10);
    rx_backlog.push_back(8'(len >> 8));
    rx_backlog.push_back(8'(len));
    // a rejected length usually ends the frame here
    if (len > ml && $urandom_range(0, 3) != 0) return;
    x = '0;
    for (int i = 0; i < len && i < 64; i++) begin
      r = $urandom_range(0, 7);
      pb = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      x ^= pb;
      rx_backlog.push_back(pb);
    end
    rx_backlog.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : x);
    r = $urandom_range(0, 19);
    rx_backlog.push_back((r == 0) ? 8'($urandom) : END_FIRST);
    rx_backlog.push_back((r == 1) ? 8'($urandom) : END_SECOND);
    // now and then a truncated frame
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3))
        if (rx_backlog.size() != 0) void'(rx_backlog.pop_back());
  endtask

  // Stop sending and wait until every expected beat has come out; the last
  // byte's result is queued at its own accept edge, so look after that edge
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    drv_pinned <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames
    in_idle_pct = 30;
    out_idle_pct = 30;
    load_limits(MAX_LEN_RESET, 8'd2);
    foreach (directed_rows[i])
      send_rx(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);
    settle();

    // Random traffic, one limit setting per phase; the last phase runs without idling
    for (int p = 0; p < N_PHASES; p++) begin
      in_idle_pct = ph_idle[p];
      out_idle_pct = ph_idle[p];
      load_limits(16'(ph_max[p]), 8'(ph_lim[p]));
      sent = 0;
      while (sent < ph_items[p] || rx_backlog.size() != 0) begin
        if (rx_backlog.size() == 0) add_frame();
        send_rx(rx_backlog.pop_front(), 1'b0, NO_RESULT);
        sent++;
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("binary_message_deframer_tb OK");
    end else begin
      $display("binary_message_deframer_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("binary_message_deframer_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bmd_pkg.sv
rtl/bmd_fsm.sv
rtl/bmd_outbuf.sv
rtl/binary_message_deframer.sv
verif/binary_message_deframer_tb.sv
